// ===== hdl/dbhp_pkg.sv =====
`default_nettype none
package dbhp_pkg;

  localparam int VERTS      = 4096;
  localparam int VERT_W     = 12;
  localparam int PARTS      = 16;
  localparam int PART_W     = 4;
  localparam int PCNT_W     = 5;
  localparam int DEG_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int VCNT_W     = 13;
  localparam logic [VCNT_W-1:0] VCNT_MAX = {VCNT_W{1'b1}};

  // Item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_HASH   = 2'd1;
  localparam logic [1:0] MODE_ASSIGN = 2'd2;
  localparam logic [1:0] MODE_ROUTE  = 2'd3;

  // One vertex row of the state memory
  typedef struct packed {
    logic [PARTS-1:0][DEG_W-1:0] pdeg;
    logic [PART_W-1:0]           asg;
    logic                        touched;
    logic [PARTS-1:0]            mirror;
    logic [DEG_W-1:0]            degree;
  } vrow_t;

endpackage
`default_nettype wire

// ===== hdl/dbhp_div.sv =====
`default_nettype none
// Q0.16 ratio num/den, saturated to all ones when num >= den.
// One quotient bit per cycle.
module dbhp_div
  import dbhp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DEG_W-1:0]   num,
  input  wire logic [DEG_W:0]     den,
  output logic                    done,
  output logic [FRAC_W-1:0]       quo
);

  logic              busy;
  logic [4:0]        cnt;
  logic [DEG_W:0]    rem;
  logic [DEG_W+1:0]  dbl;
  logic              take;

  assign dbl  = {rem, 1'b0};
  assign take = dbl >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if ({1'b0, num} >= den) begin
          quo  <= {FRAC_W{1'b1}};
          done <= 1'b1;
        end else begin
          rem  <= {1'b0, num};
          quo  <= '0;
          cnt  <= 5'(FRAC_W);
          busy <= 1'b1;
        end
      end else if (busy) begin
        // shift-subtract step
        quo <= {quo[FRAC_W-2:0], take};
        rem <= take ? (DEG_W+1)'(dbl - {1'b0, den}) : dbl[DEG_W:0];
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/degree_based_hash_edge_partitioner.sv =====
`default_nettype none
// Degree-based hash edge partitioner. All per-vertex state (degree, mirror
// bits, touched flag, assigned partition and the sixteen per-partition degree
// counts) sits in one 4096-row memory with a read and a write port, read
// and written back a row at a time. After reset a clearing pass writes every
// row to zero, one row a cycle, and no item is taken until it is done;
// part_count writes are taken throughout. One item is in work at a time. A
// hash item takes two row reads, a 12-step modulo by the partition count
// and two row writes. An assignment scans the p partitions and passes each
// mirror through the bit-serial 16-bit ratio divider. The result sits in
// an output register, so the next item is taken while it waits.
module degree_based_hash_edge_partitioner
  import dbhp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [PCNT_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        mode,
  input  wire logic [VERT_W-1:0] vertex_a,
  input  wire logic [VERT_W-1:0] vertex_b,
  input  wire logic [DEG_W-1:0]  degree_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             mode_echo,
  output logic [PART_W-1:0]      partition,
  output logic [PART_W-1:0]      partition_b,
  output logic                   valid_res
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_GETA  = 12'b000000000100,
    S_GETB  = 12'b000000001000,
    S_MOD   = 12'b000000010000,
    S_WRA   = 12'b000000100000,
    S_WRB   = 12'b000001000000,
    S_WR0   = 12'b000010000000,
    S_SCAN  = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_WRV   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration and derived partition count
  logic [PCNT_W-1:0] part_count;
  logic [PCNT_W-1:0] p_eff;

  assign cfg_ready = 1'b1;
  assign p_eff = (part_count == '0) ? PCNT_W'(1) :
                 (part_count > PCNT_W'(PARTS)) ? PCNT_W'(PARTS) : part_count;

  // Latched item
  logic [1:0]        mode_r;
  logic [VERT_W-1:0] va_r, vb_r;
  logic [DEG_W-1:0]  deg_r;

  // Rows and working registers
  vrow_t             row_a, row_b;
  logic [VERT_W-1:0] clr_cnt;
  logic [VERT_W-1:0] w_r;
  logic [3:0]        mod_cnt;
  logic [PCNT_W-1:0] mod_rem;
  logic [PART_W-1:0] bucket;
  logic [PCNT_W-1:0] j;
  logic              found;
  logic [PART_W-1:0] best;
  logic [FRAC_W:0]   best_score;

  // Small counter files
  logic [VCNT_W-1:0] touched_count;
  logic [PARTS-1:0][DEG_W-1:0]  edge_counts;
  logic [PARTS-1:0][VCNT_W-1:0] vertex_counts;

  // Result holding
  logic [PART_W-1:0] res_part, res_part_b;
  logic              res_valid;

  // State memory
  vrow_t             mem [VERTS];
  vrow_t             rdata;
  logic              mem_re, mem_we;
  logic [VERT_W-1:0] mem_raddr, mem_waddr;
  vrow_t             mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  assign in_ready = (state == S_IDLE);

  // Mark an edge end on a row
  function automatic vrow_t touch_row(input vrow_t r, input logic [PART_W-1:0] bk);
    vrow_t t;
    t = r;
    t.mirror[bk] = 1'b1;
    t.pdeg[bk]   = r.pdeg[bk] + DEG_W'(1);
    t.touched    = 1'b1;
    return t;
  endfunction

  vrow_t row_a_mod, row_b_mod;
  assign row_a_mod = touch_row(row_a, bucket);
  assign row_b_mod = touch_row(row_b, bucket);

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = vertex_a;
    mem_we    = 1'b0;
    mem_waddr = va_r;
    mem_wdata = row_a;
    unique case (state)
      S_IDLE: mem_re = in_valid;
      S_GETA: begin
        mem_re    = 1'b1;
        mem_raddr = vb_r;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_WR0: begin
        mem_we           = 1'b1;
        mem_wdata.degree = deg_r;
      end
      S_WRA: begin
        mem_we    = 1'b1;
        mem_wdata = row_a_mod;
      end
      S_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = vb_r;
        mem_wdata = row_b_mod;
      end
      S_WRV: begin
        mem_we        = 1'b1;
        mem_wdata.asg = best;
      end
      default: ;
    endcase
  end

  // Modulo step
  logic [PCNT_W:0] mod_sh;
  logic [PCNT_W:0] mod_nx;
  assign mod_sh = {mod_rem, w_r[mod_cnt]};
  assign mod_nx = (mod_sh >= {1'b0, p_eff}) ? (mod_sh - {1'b0, p_eff}) : mod_sh;

  // Ratio divider
  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quo;

  assign div_start = (state == S_SCAN) && (j != p_eff) && row_a.mirror[j[PART_W-1:0]];

  dbhp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (row_a.pdeg[j[PART_W-1:0]]),
    .den   ((DEG_W+1)'({1'b0, row_a.degree} + (DEG_W+1)'(1))),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Capacity test and score
  logic [PART_W-1:0] vc_idx;
  logic [VCNT_W-1:0] vc_sel;
  logic [17:0]       pv;
  logic [24:0]       cap_lhs, cap_rhs;
  logic [FRAC_W:0]   score;

  assign vc_idx  = (state == S_WRV) ? best : j[PART_W-1:0];
  assign vc_sel  = vertex_counts[vc_idx];
  assign pv      = 18'(p_eff) * 18'(vc_sel);
  assign cap_lhs = 25'(pv) * 25'd100;
  assign cap_rhs = 25'(touched_count) * 25'd105 + 25'(p_eff) * 25'd100;
  assign score   = {cap_lhs < cap_rhs, div_quo};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      part_count    <= PCNT_W'(4);
      touched_count <= '0;
      edge_counts   <= '0;
      vertex_counts <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) part_count <= cfg_data;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + VERT_W'(1);
          if (clr_cnt == {VERT_W{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            va_r   <= vertex_a;
            vb_r   <= vertex_b;
            deg_r  <= degree_value;
            state  <= S_GETA;
          end
        end
        S_GETA: begin
          row_a      <= rdata;
          j          <= '0;
          found      <= 1'b0;
          best       <= '0;
          best_score <= '0;
          case (mode_r)
            MODE_LOAD:   state <= S_WR0;
            MODE_ASSIGN: state <= S_SCAN;
            default:     state <= S_GETB;
          endcase
        end
        S_GETB: begin
          row_b <= rdata;
          if (mode_r == MODE_ROUTE) begin
            res_part   <= row_a.asg;
            res_part_b <= rdata.asg;
            res_valid  <= 1'b1;
            state      <= S_DONE;
          end else begin
            w_r     <= (row_a.degree <= rdata.degree) ? va_r : vb_r;
            mod_cnt <= 4'(VERT_W - 1);
            mod_rem <= '0;
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          mod_rem <= mod_nx[PCNT_W-1:0];
          mod_cnt <= mod_cnt - 4'd1;
          if (mod_cnt == 4'd0) begin
            bucket <= mod_nx[PART_W-1:0];
            state  <= S_WRA;
          end
        end
        S_WRA: begin
          edge_counts[bucket] <= edge_counts[bucket] + DEG_W'(1);
          if (!row_a.touched) touched_count <= touched_count + VCNT_W'(1);
          // self-loop: second end builds on the first one's update
          if (va_r == vb_r) row_b <= row_a_mod;
          state <= S_WRB;
        end
        S_WRB: begin
          if (!row_b.touched) touched_count <= touched_count + VCNT_W'(1);
          res_part   <= bucket;
          res_part_b <= '0;
          res_valid  <= 1'b1;
          state      <= S_DONE;
        end
        S_WR0: begin
          res_part   <= '0;
          res_part_b <= '0;
          res_valid  <= 1'b0;
          state      <= S_DONE;
        end
        S_SCAN: begin
          if (j == p_eff) begin
            res_part_b <= '0;
            if (found) begin
              state <= S_WRV;
            end else begin
              res_part  <= '0;
              res_valid <= 1'b0;
              state     <= S_DONE;
            end
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            j <= j + PCNT_W'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            found <= 1'b1;
            // first mirror is the starting choice
            if (!found || score > best_score) best <= j[PART_W-1:0];
            if (score > best_score) best_score <= score;
            j     <= j + PCNT_W'(1);
            state <= S_SCAN;
          end
        end
        S_WRV: begin
          if (vc_sel < VCNT_MAX) vertex_counts[best] <= vc_sel + VCNT_W'(1);
          res_part  <= best;
          res_valid <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          // hand over once the output slot is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            mode_echo   <= mode_r;
            partition   <= res_part;
            partition_b <= res_part_b;
            valid_res   <= res_valid;
            state       <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside the scoring step");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result dropped while output slot is occupied");

  a_invalid_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (mode_echo == MODE_LOAD || mode_echo == MODE_ASSIGN))
    else $error("invalid result for a hash or route item");

endmodule
`default_nettype wire

// ===== dv/degree_based_hash_edge_partitioner_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module degree_based_hash_edge_partitioner_test;
  import dbhp_pkg::*;

  typedef struct packed {
    logic [1:0]        mode;
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb;
    logic [DEG_W-1:0]  deg;
  } edge_item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PART_W-1:0] part;
    logic [PART_W-1:0] part_b;
    logic              ok;
  } route_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [PCNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [VERT_W-1:0] vertex_a = '0;
  logic [VERT_W-1:0] vertex_b = '0;
  logic [DEG_W-1:0] degree_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] mode_echo;
  logic [PART_W-1:0] partition;
  logic [PART_W-1:0] partition_b;
  logic valid_res;

  degree_based_hash_edge_partitioner DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .degree_value(degree_value),
    .out_valid(out_valid), .out_ready(out_ready), .mode_echo(mode_echo),
    .partition(partition), .partition_b(partition_b), .valid_res(valid_res)
  );

  always #4 clk = ~clk;

  // Shadow state of the partitioner
  logic [PCNT_W-1:0] sh_pcount;
  logic [DEG_W-1:0]  sh_degree [VERTS];
  logic [PARTS-1:0]  sh_mirror [VERTS];
  logic [DEG_W-1:0]  sh_pdeg [VERTS][PARTS];
  logic              sh_touched [VERTS];
  int unsigned       sh_touch_cnt;
  int unsigned       sh_vcount [PARTS];
  logic [PART_W-1:0] sh_assign [VERTS];

  edge_item_t pending_items[$];
  route_res_t expected_parts[$];
  int fail_count = 0;
  int sent_count = 0;
  int recv_count = 0;
  int hold_cycles = 0;

  function automatic void clear_shadow();
    sh_pcount = 5'd4;
    sh_touch_cnt = 0;
    for (int v = 0; v < VERTS; v++) begin
      sh_degree[v] = '0;
      sh_mirror[v] = '0;
      sh_touched[v] = 1'b0;
      sh_assign[v] = '0;
      for (int j = 0; j < PARTS; j++) sh_pdeg[v][j] = '0;
    end
    for (int j = 0; j < PARTS; j++) sh_vcount[j] = 0;
  endfunction

  function automatic void mark_mirror(int v, int bucket);
    sh_mirror[v][bucket] = 1'b1;
    sh_pdeg[v][bucket] = sh_pdeg[v][bucket] + 1;
    if (!sh_touched[v]) begin
      sh_touched[v] = 1'b1;
      sh_touch_cnt++;
    end
  endfunction

  function automatic longint unsigned mirror_score(int v, int j, int p);
    longint unsigned ratio;
    longint unsigned s;
    ratio = ({32'd0, sh_pdeg[v][j]} << 16) / ({32'd0, sh_degree[v]} + 64'd1);
    if (ratio > 65535) ratio = 65535;
    s = ratio;
    if (100 * longint'(p) * sh_vcount[j] < 105 * longint'(sh_touch_cnt) + 100 * longint'(p))
      s += 65536;
    return s;
  endfunction

  // Work out the result of one item and update the shadow state
  function automatic route_res_t predict_partition(edge_item_t it);
    route_res_t r;
    int p, a, b, w, bucket, n, best;
    longint unsigned best_score, s;
    logic [PARTS-1:0] m;
    logic found;
    p = (sh_pcount == 0) ? 1 : (sh_pcount > PARTS) ? PARTS : int'(sh_pcount);
    a = it.va;
    b = it.vb;
    r = '0;
    r.mode = it.mode;
    case (it.mode)
      MODE_LOAD: begin
        sh_degree[a] = it.deg;
      end
      MODE_HASH: begin
        w = (sh_degree[a] <= sh_degree[b]) ? a : b;
        bucket = w % p;
        mark_mirror(a, bucket);
        mark_mirror(b, bucket);
        r.part = PART_W'(bucket);
        r.ok = 1'b1;
      end
      MODE_ASSIGN: begin
        m = sh_mirror[a];
        for (int j = p; j < PARTS; j++) m[j] = 1'b0;
        if (m != '0) begin
          n = $countones(m);
          best = 0;
          best_score = 0;
          found = 1'b0;
          for (int j = 0; j < p; j++) begin
            if (m[j]) begin
              if (!found) begin
                best = j;
                found = 1'b1;
                if (n == 1) break;
              end
              s = mirror_score(a, j, p);
              if (s > best_score) begin
                best_score = s;
                best = j;
              end
            end
          end
          if (sh_vcount[best] < 8191) sh_vcount[best]++;
          sh_assign[a] = PART_W'(best);
          r.part = PART_W'(best);
          r.ok = 1'b1;
        end
      end
      default: begin
        r.part = sh_assign[a];
        r.part_b = sh_assign[b];
        r.ok = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic void push_item(logic [1:0] md, int va, int vb, logic [31:0] dg);
    edge_item_t it;
    it.mode = md;
    it.va = VERT_W'(va);
    it.vb = VERT_W'(vb);
    it.deg = dg;
    pending_items.push_back(it);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers pending items, holds payload until transferred
  int drv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_parts.push_back(predict_partition({mode, vertex_a, vertex_b, degree_value}));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          edge_item_t it;
          it = pending_items.pop_front();
          mode <= it.mode;
          vertex_a <= it.va;
          vertex_b <= it.vb;
          degree_value <= it.deg;
          in_valid <= 1'b1;
          drv_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and stalls the receiver at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        recv_count++;
        if (expected_parts.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          route_res_t e;
          e = expected_parts.pop_front();
          if (mode_echo !== e.mode) begin
            $error("mode_echo expected %0d actual %0d", e.mode, mode_echo);
            fail_count++;
          end
          if (partition !== e.part) begin
            $error("partition expected %0d actual %0d", e.part, partition);
            fail_count++;
          end
          if (partition_b !== e.part_b) begin
            $error("partition_b expected %0d actual %0d", e.part_b, partition_b);
            fail_count++;
          end
          if (valid_res !== e.ok) begin
            $error("valid_res expected %0d actual %0d", e.ok, valid_res);
            fail_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (gap_len() == 0);
      end
    end
  end

  task automatic write_pcount(logic [PCNT_W-1:0] val);
    @(posedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_pcount = val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_parts.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic int rand_vertex(int pool);
    return (pool == 0) ? $urandom_range(0, VERTS - 1) : $urandom_range(0, pool - 1);
  endfunction

  // Mostly a small working set so that hashing builds mirrors worth assigning
  function automatic void random_phase(int count);
    int pool, r, va;
    logic [31:0] dg;
    for (int i = 0; i < count; i++) begin
      pool = ($urandom_range(0, 9) == 0) ? 0 : 48;
      r = $urandom_range(0, 99);
      va = rand_vertex(pool);
      if (r < 15) begin
        case ($urandom_range(0, 3))
          0: dg = $urandom;
          1: dg = 32'hFFFF_FFFF;
          default: dg = $urandom_range(0, 20);
        endcase
        push_item(MODE_LOAD, va, rand_vertex(pool), dg);
      end else if (r < 55) begin
        push_item(MODE_HASH, va, rand_vertex(pool), $urandom);
      end else if (r < 80) begin
        push_item(MODE_ASSIGN, va, $urandom, $urandom);
      end else begin
        push_item(MODE_ROUTE, va, rand_vertex(pool), $urandom);
      end
    end
  endfunction

  initial begin
    #50_000_000;
    $display("degree_based_hash_edge_partitioner regression: fail");
    $finish;
  end

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, self-loop, unmirrored vertex, unassigned routing
    push_item(MODE_ASSIGN, 7, 0, 0);
    push_item(MODE_ROUTE, 4095, 0, 0);
    push_item(MODE_LOAD, 0, 0, 32'hFFFF_FFFF);
    push_item(MODE_LOAD, 4095, 4095, 0);
    push_item(MODE_LOAD, 1, 0, 32'd1);
    push_item(MODE_HASH, 0, 4095, 0);
    push_item(MODE_HASH, 4095, 0, 0);
    push_item(MODE_HASH, 1, 1, 0);
    push_item(MODE_HASH, 1, 2, 0);
    push_item(MODE_HASH, 2, 3, 0);
    push_item(MODE_HASH, 1, 3, 0);
    push_item(MODE_ASSIGN, 1, 0, 0);
    push_item(MODE_ASSIGN, 1, 0, 0);
    push_item(MODE_ASSIGN, 2, 0, 0);
    push_item(MODE_ASSIGN, 3, 0, 0);
    push_item(MODE_ASSIGN, 4095, 0, 0);
    push_item(MODE_ASSIGN, 0, 0, 0);
    push_item(MODE_ROUTE, 1, 4095, 0);
    push_item(MODE_ROUTE, 2, 3, 0);
    drain();

    // Receiver holds off while the sender keeps offering items
    hold_cycles = 600;
    random_phase(150);
    drain();

    // Partition count settings, extremes included; mirrors above p are masked
    write_pcount(5'd16);
    random_phase(200);
    drain();
    write_pcount(5'd1);
    random_phase(100);
    drain();
    write_pcount(5'd0);
    random_phase(60);
    drain();
    write_pcount(5'd31);
    random_phase(120);
    drain();
    write_pcount(5'd3);
    random_phase(150);
    drain();
    write_pcount(5'd7);
    random_phase(150);
    drain();

    if (fail_count == 0 && expected_parts.size() == 0)
      $display("degree_based_hash_edge_partitioner regression: pass");
    else
      $display("degree_based_hash_edge_partitioner regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/dbhp_pkg.sv
hdl/dbhp_div.sv
hdl/degree_based_hash_edge_partitioner.sv
dv/degree_based_hash_edge_partitioner_test.sv
